// ----- rtl/core/light_effect_pwm_engine_defines.svh -----
// assertion helpers for the light effect engine
`ifndef LIGHT_EFFECT_PWM_ENGINE_DEFINES_SVH
`define LIGHT_EFFECT_PWM_ENGINE_DEFINES_SVH

// same-cycle implication on the rising edge of clk
`define LEPE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication on the rising edge of clk
`define LEPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- rtl/core/lepe_pkg.sv -----
package lepe_pkg;

	localparam int SINE_ENTRIES_DEF = 256;
	localparam int TIME_BITS_DEF    = 32;
	localparam int APB_ADDR_BITS    = 3;

	// pi/4 in q2.30
	localparam logic [63:0] PI_QUARTER_Q30 = 64'd843314857;

	// shared divider: numerator bits, bits retired per cycle
	localparam int DIV_NUM_BITS = 44;
	localparam int DIV_STEPS    = 4;
	localparam int DIV_CYCLES   = DIV_NUM_BITS / DIV_STEPS;
	localparam int DIV_CNT_BITS = $clog2(DIV_CYCLES);

	localparam logic [7:0]  BRIGHTNESS_RESET  = 8'd255;
	localparam logic [15:0] BREATH_RATE_RESET = 16'd256;

	// register indexes, decoded from paddr[2]
	localparam logic REG_BRIGHTNESS  = 1'b0;
	localparam logic REG_BREATH_RATE = 1'b1;

	typedef enum logic [3:0] {
		EFF_IDLE      = 4'd0,
		EFF_OFF       = 4'd1,
		EFF_ON        = 4'd2,
		EFF_FADE_ON   = 4'd3,
		EFF_FADE_OFF  = 4'd4,
		EFF_BREATH    = 4'd5,
		EFF_BLINK     = 4'd6,
		EFF_BLINK_OFF = 4'd7,
		EFF_BLINK_ON  = 4'd8
	} effect_t;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_SET    = 2'd1,
		CMD_PERIOD = 2'd2,
		CMD_NONE   = 2'd3
	} command_t;

	typedef struct packed {
		logic capture;
		logic apply;
		logic prep;
		logic exec;
		logic div_step;
		logic post;
		logic index;
		logic rom_rd;
		logic shade;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic tick_cmd;
		logic need_div;
		logic div_last;
		logic breath;
	} ctrl_stat_t;

	typedef struct packed {
		logic [7:0] duty;
		logic       lamp_on;
		logic [3:0] effect_now;
		logic       active;
	} result_t;

endpackage

// ----- rtl/core/lepe_if.sv -----
interface lepe_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [3:0]  effect;
	logic [31:0] time_ms;
	logic [15:0] first_value;
	logic [15:0] second_value;
	logic [15:0] third_value;

	modport source (
		output valid, command, effect, time_ms, first_value, second_value, third_value,
		input  ready
	);
	modport sink (
		input  valid, command, effect, time_ms, first_value, second_value, third_value,
		output ready
	);
endinterface

interface lepe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] duty;
	logic       lamp_on;
	logic [3:0] effect_now;
	logic       active;

	modport source (
		output valid, duty, lamp_on, effect_now, active,
		input  ready
	);
	modport sink (
		input  valid, duty, lamp_on, effect_now, active,
		output ready
	);
endinterface

// ----- rtl/core/lepe_ctrl.sv -----
module lepe_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  out_free,
	input  lepe_pkg::ctrl_stat_t  stat,
	output lepe_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_APPLY = 10'b0000000010,
		S_PREP  = 10'b0000000100,
		S_EXEC  = 10'b0000001000,
		S_DIV   = 10'b0000010000,
		S_POST  = 10'b0000100000,
		S_INDEX = 10'b0001000000,
		S_ROM   = 10'b0010000000,
		S_SHADE = 10'b0100000000,
		S_FIN   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_APPLY;
			S_APPLY: state_d = stat.tick_cmd ? S_PREP : S_FIN;
			S_PREP:  state_d = S_EXEC;
			S_EXEC:  state_d = stat.need_div ? S_DIV : S_FIN;
			S_DIV:   if (stat.div_last) state_d = S_POST;
			S_POST:  state_d = stat.breath ? S_INDEX : S_FIN;
			S_INDEX: state_d = S_ROM;
			S_ROM:   state_d = S_SHADE;
			S_SHADE: state_d = S_FIN;
			S_FIN:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready     = (state_q == S_IDLE);
	assign cmd.capture  = (state_q == S_IDLE) && in_valid;
	assign cmd.apply    = (state_q == S_APPLY);
	assign cmd.prep     = (state_q == S_PREP);
	assign cmd.exec     = (state_q == S_EXEC);
	assign cmd.div_step = (state_q == S_DIV);
	assign cmd.post     = (state_q == S_POST);
	assign cmd.index    = (state_q == S_INDEX);
	assign cmd.rom_rd   = (state_q == S_ROM);
	assign cmd.shade    = (state_q == S_SHADE);
	assign cmd.load_out = (state_q == S_FIN) && out_free;

endmodule

// ----- rtl/core/lepe_dp.sv -----
module lepe_dp #(
	parameter int SINE_ENTRIES = lepe_pkg::SINE_ENTRIES_DEF,
	parameter int TIME_BITS    = lepe_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lepe_pkg::ctrl_cmd_t  cmd,
	output lepe_pkg::ctrl_stat_t stat,
	input  logic [1:0]           command,
	input  logic [3:0]           effect,
	input  logic [31:0]          time_ms,
	input  logic [15:0]          first_value,
	input  logic [15:0]          second_value,
	input  logic [15:0]          third_value,
	input  logic [7:0]           brightness,
	input  logic [15:0]          breath_rate,
	output lepe_pkg::result_t    result
);

	localparam int IW  = $clog2(SINE_ENTRIES);
	localparam int IW1 = IW + 1;
	localparam int PW  = 17 + IW;
	localparam int DNB = lepe_pkg::DIV_NUM_BITS;
	localparam int DCB = lepe_pkg::DIV_CNT_BITS;

	typedef logic [15:0] rom_t [SINE_ENTRIES];

	// sine from 0 to pi/4, taylor series to x^11 in q2.30, rounded to q0.16
	function automatic rom_t build_rom();
		rom_t              rom;
		logic [63:0]       x;
		logic [63:0]       t;
		logic [63:0]       v;
		logic signed [63:0] sum;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			x   = (lepe_pkg::PI_QUARTER_Q30 * 64'(k)) / 64'(SINE_ENTRIES - 1);
			t   = x;
			sum = x;
			t   = (((t * x) >> 30) * x) >> 30;
			t   = t / 64'd6;
			sum = sum - $signed(t);
			t   = (((t * x) >> 30) * x) >> 30;
			t   = t / 64'd20;
			sum = sum + $signed(t);
			t   = (((t * x) >> 30) * x) >> 30;
			t   = t / 64'd42;
			sum = sum - $signed(t);
			t   = (((t * x) >> 30) * x) >> 30;
			t   = t / 64'd72;
			sum = sum + $signed(t);
			t   = (((t * x) >> 30) * x) >> 30;
			t   = t / 64'd110;
			sum = sum - $signed(t);
			if (sum < 0) sum = '0;
			v = (64'(sum) + 64'd8192) >> 14;
			if (v > 64'd65535) v = 64'd65535;
			rom[k] = v[15:0];
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// effect state
	lepe_pkg::effect_t      mode_q;
	logic [TIME_BITS-1:0]   start_q;
	logic [TIME_BITS-1:0]   last_q;
	logic [15:0]            pa_q;
	logic [15:0]            pb_q;
	logic [15:0]            pc_q;
	logic [16:0]            phase_q;
	logic                   level_q;
	logic [7:0]             duty_q;

	// captured transaction
	lepe_pkg::command_t     cmd_q;
	logic [3:0]             eff_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [15:0]            v1_q;
	logic [15:0]            v2_q;
	logic [15:0]            v3_q;

	// working registers
	logic [16:0]            since_q;
	logic [20:0]            elapsed_q;
	logic [DNB-1:0]         num_q;
	logic [16:0]            rem_q;
	logic [15:0]            den_q;
	logic [DCB-1:0]         cnt_q;
	logic [IW-1:0]          idx_q;
	logic [15:0]            sine_q;

	// time differences, saturated to what the effects can tell apart
	logic [TIME_BITS-1:0]   since_full;
	logic [TIME_BITS-1:0]   elapsed_full;
	logic [63:0]            since64;
	logic [63:0]            elapsed64;
	logic [16:0]            since_n;
	logic [20:0]            elapsed_n;

	assign since_full   = (start_q > now_q) ? '0 : now_q - start_q;
	assign elapsed_full = now_q - last_q;
	assign since64      = 64'(since_full);
	assign elapsed64    = 64'(elapsed_full);
	assign since_n      = (since64 > 64'd65535) ? 17'd65536 : since64[16:0];
	assign elapsed_n    = (elapsed64 > 64'd1048576) ? 21'd1048576 : elapsed64[20:0];

	// divider operands
	logic [15:0]    fade_sel;
	logic [15:0]    fade_t;
	logic [23:0]    fade_prod;
	logic [36:0]    breath_prod;
	logic [DNB-1:0] div_num;
	logic [15:0]    div_den;
	logic           is_breath;
	logic           is_fade;

	assign is_breath   = (mode_q == lepe_pkg::EFF_BREATH);
	assign is_fade     = (mode_q == lepe_pkg::EFF_FADE_ON) || (mode_q == lepe_pkg::EFF_FADE_OFF);
	assign fade_sel    = (since_q >= {1'b0, pa_q}) ? pa_q : since_q[15:0];
	assign fade_t      = (mode_q == lepe_pkg::EFF_FADE_OFF) ? pa_q - fade_sel : fade_sel;
	assign fade_prod   = 24'(fade_t) * 24'(brightness);
	assign breath_prod = 37'(breath_rate) * 37'(elapsed_q);

	always_comb begin
		if (is_breath) begin
			// rising rate*256/1000, falling 1.6 times that
			if (pc_q == 16'd1) begin
				div_num = DNB'(breath_prod) << 5;
				div_den = 16'd125;
			end else begin
				div_num = DNB'(breath_prod) << 8;
				div_den = 16'd625;
			end
		end else begin
			div_num = DNB'(fade_prod);
			div_den = pa_q;
		end
	end

	// restoring divider, several quotient bits per cycle
	logic [DNB-1:0] num_n;
	logic [16:0]    rem_n;

	always_comb begin
		num_n = num_q;
		rem_n = rem_q;
		for (int j = 0; j < lepe_pkg::DIV_STEPS; j++) begin
			rem_n = {rem_n[15:0], num_n[DNB-1]};
			num_n = {num_n[DNB-2:0], 1'b0};
			if (rem_n >= {1'b0, den_q}) begin
				rem_n    = rem_n - {1'b0, den_q};
				num_n[0] = 1'b1;
			end
		end
	end

	// breathing phase update
	logic [16:0]        q_sat;
	logic signed [18:0] ph_c;

	assign q_sat = (|num_q[DNB-1:17]) ? 17'h1FFFF : num_q[16:0];
	assign ph_c  = (pc_q == 16'd1) ? {2'b00, phase_q} + {2'b00, q_sat}
	                               : {2'b00, phase_q} - {2'b00, q_sat};

	// sine index, rounded
	logic [PW-1:0] idx_sum;
	logic [IW:0]   idx_sh;
	logic [IW-1:0] idx_n;

	assign idx_sum = PW'(phase_q) * PW'(SINE_ENTRIES - 1) + PW'(32768);
	assign idx_sh  = idx_sum[PW-1:16];
	assign idx_n   = (idx_sh > IW1'(SINE_ENTRIES - 1)) ? IW'(SINE_ENTRIES - 1) : idx_sh[IW-1:0];

	logic [24:0] shade_prod;
	assign shade_prod = 25'(17'h10000 - {1'b0, sine_q}) * 25'(brightness);

	logic [15:0] pa_dec;
	assign pa_dec = pa_q - 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lepe_pkg::EFF_OFF;
			start_q <= '0;
			last_q  <= '0;
			pa_q    <= '0;
			pb_q    <= '0;
			pc_q    <= '0;
			phase_q <= '0;
			level_q <= 1'b0;
			duty_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd.apply) begin
				case (cmd_q)
					lepe_pkg::CMD_SET: begin
						level_q <= 1'b1;
						duty_q  <= brightness;
						last_q  <= now_q;
						start_q <= now_q;
						pa_q    <= v1_q;
						pb_q    <= v2_q;
						pc_q    <= v3_q;
						phase_q <= '0;
						mode_q  <= (eff_q > 4'd8) ? lepe_pkg::EFF_IDLE
						                          : lepe_pkg::effect_t'(eff_q);
					end
					lepe_pkg::CMD_PERIOD: begin
						pa_q <= v1_q;
						pb_q <= v1_q;
					end
					default: ;
				endcase
			end

			// a timestamp behind the start pulls the start back
			if (cmd.prep && (start_q > now_q)) start_q <= now_q;

			if (cmd.exec) begin
				last_q <= now_q;
				cnt_q  <= '0;
				case (mode_q)
					lepe_pkg::EFF_OFF: begin
						level_q <= 1'b0;
						duty_q  <= '0;
						mode_q  <= lepe_pkg::EFF_IDLE;
					end
					lepe_pkg::EFF_ON: begin
						level_q <= 1'b1;
						duty_q  <= brightness;
					end
					lepe_pkg::EFF_FADE_ON, lepe_pkg::EFF_FADE_OFF: begin
						if (pa_q == 16'd0) duty_q <= brightness;
					end
					lepe_pkg::EFF_BLINK: begin
						if (level_q) begin
							if (since_q > {1'b0, pa_q}) begin
								level_q <= 1'b0;
								duty_q  <= '0;
								start_q <= now_q;
							end
						end else if (since_q > {1'b0, pb_q}) begin
							level_q <= 1'b1;
							duty_q  <= brightness;
							start_q <= now_q;
						end
					end
					lepe_pkg::EFF_BLINK_OFF, lepe_pkg::EFF_BLINK_ON: begin
						if (level_q) begin
							if (since_q > {1'b0, pb_q}) begin
								level_q <= 1'b0;
								duty_q  <= '0;
								start_q <= now_q;
								pa_q    <= pa_dec;
								if ((pa_dec == 16'd0) && (mode_q == lepe_pkg::EFF_BLINK_OFF))
									mode_q <= lepe_pkg::EFF_OFF;
							end
						end else if (since_q > {1'b0, pc_q}) begin
							level_q <= 1'b1;
							duty_q  <= brightness;
							start_q <= now_q;
							if ((pa_q == 16'd1) && (mode_q == lepe_pkg::EFF_BLINK_ON))
								mode_q <= lepe_pkg::EFF_ON;
						end
					end
					default: ;
				endcase
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + DCB'(1);
			end

			if (cmd.post) begin
				if (is_breath) begin
					if (ph_c > 19'sd65536) begin
						phase_q <= 17'd65536;
						pc_q    <= 16'd0;
					end else if (ph_c < 19'sd0) begin
						phase_q <= '0;
						pc_q    <= 16'd1;
					end else begin
						phase_q <= ph_c[16:0];
					end
				end else begin
					duty_q <= num_q[7:0];
				end
			end

			if (cmd.shade) duty_q <= shade_prod[23:16];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= lepe_pkg::command_t'(command);
			eff_q <= effect;
			now_q <= TIME_BITS'(time_ms);
			v1_q  <= first_value;
			v2_q  <= second_value;
			v3_q  <= third_value;
		end
		if (cmd.prep) begin
			since_q   <= since_n;
			elapsed_q <= elapsed_n;
		end
		if (cmd.exec) begin
			num_q <= div_num;
			den_q <= div_den;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= num_n;
			rem_q <= rem_n;
		end
		if (cmd.index) idx_q <= idx_n;
		if (cmd.rom_rd) sine_q <= SINE_ROM[idx_q];
	end

	assign stat.tick_cmd = (cmd_q == lepe_pkg::CMD_TICK) || (cmd_q == lepe_pkg::CMD_SET);
	assign stat.need_div = is_breath || (is_fade && (pa_q != 16'd0));
	assign stat.div_last = (cnt_q == DCB'(lepe_pkg::DIV_CYCLES - 1));
	assign stat.breath   = is_breath;

	assign result.duty       = duty_q;
	assign result.lamp_on    = level_q;
	assign result.effect_now = mode_q;
	assign result.active     = (mode_q != lepe_pkg::EFF_IDLE) && (mode_q != lepe_pkg::EFF_OFF);

endmodule

// ----- rtl/core/light_effect_pwm_engine.sv -----
// light effect pwm engine
//
// in_ch carries one transaction per millisecond event: a command (tick, set
// effect, set blink period), an effect code, the timestamp and three values.
// out_ch returns exactly one transaction per input: the pwm duty, the lamp
// level, the effect now running and an active flag.
// the apb port holds brightness (byte 0) and breath_rate (byte 4); write it
// only while no transaction is in flight.
// one transaction is worked at a time. a period or unused command goes
// straight from apply to the output; a tick of off, on, blink or a
// zero-length fade goes through prep and exec; a fade also runs the shared
// radix-16 divider and a post step, and breathing adds an index multiply,
// a sine table read and a scaling multiply. the next transaction is taken
// in the cycle after the result is registered.
// the result sits in an output register, so a stalled receiver holds only
// that result; a second result waits in the controller until it is taken.
// reset puts the effect to off with the lamp dark, brightness 255 and
// breath_rate 1.0 per second.
module light_effect_pwm_engine #(
	parameter int SINE_ENTRIES = lepe_pkg::SINE_ENTRIES_DEF,
	parameter int TIME_BITS    = lepe_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	lepe_in_if.sink                            in_ch,
	lepe_out_if.source                         out_ch,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lepe_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	// configuration registers
	logic [7:0]  brightness_q;
	logic [15:0] breath_rate_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q  <= lepe_pkg::BRIGHTNESS_RESET;
			breath_rate_q <= lepe_pkg::BREATH_RATE_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				lepe_pkg::REG_BRIGHTNESS:  brightness_q  <= pwdata[7:0];
				lepe_pkg::REG_BREATH_RATE: breath_rate_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read-back, word selected by address bit 2
	always_comb begin
		case (paddr[2])
			lepe_pkg::REG_BRIGHTNESS:  prdata = {24'd0, brightness_q};
			lepe_pkg::REG_BREATH_RATE: prdata = {16'd0, breath_rate_q};
			default:                   prdata = '0;
		endcase
	end

	// controller and datapath
	lepe_pkg::ctrl_cmd_t  cmd;
	lepe_pkg::ctrl_stat_t stat;
	lepe_pkg::result_t    result;
	logic                 out_free;

	lepe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd)
	);

	lepe_dp #(
		.SINE_ENTRIES (SINE_ENTRIES),
		.TIME_BITS    (TIME_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.command      (in_ch.command),
		.effect       (in_ch.effect),
		.time_ms      (in_ch.time_ms),
		.first_value  (in_ch.first_value),
		.second_value (in_ch.second_value),
		.third_value  (in_ch.third_value),
		.brightness   (brightness_q),
		.breath_rate  (breath_rate_q),
		.result       (result)
	);

	// output register: free when empty or being drained this cycle
	lepe_pkg::result_t out_q;
	logic              out_valid_q;

	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) out_q <= result;
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.duty       = out_q.duty;
	assign out_ch.lamp_on    = out_q.lamp_on;
	assign out_ch.effect_now = out_q.effect_now;
	assign out_ch.active     = out_q.active;

endmodule

// ----- rtl/core/lepe_checker.sv -----
`include "light_effect_pwm_engine_defines.svh"

module lepe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] duty,
	input logic       lamp_on,
	input logic [3:0] effect_now,
	input logic       active
);

	// a stalled result holds
	`LEPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(duty) && $stable(lamp_on) && $stable(effect_now) && $stable(active), "result changed while stalled")

	// one transaction in flight: no acceptance straight after another
	`LEPE_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken twice in a row")

	`LEPE_ASSERT_NOW(a_active_flag, out_valid, active == ((effect_now != lepe_pkg::EFF_IDLE) && (effect_now != lepe_pkg::EFF_OFF)), "active flag disagrees with effect")

	// off shows a dark lamp
	`LEPE_ASSERT_NOW(a_off_dark, out_valid && (effect_now == lepe_pkg::EFF_OFF), !lamp_on && (duty == 8'd0), "effect off with lamp lit")

	// steady on always has the lamp level set
	`LEPE_ASSERT_NOW(a_on_lit, out_valid && (effect_now == lepe_pkg::EFF_ON), lamp_on, "effect on with lamp level low")

endmodule

bind light_effect_pwm_engine lepe_checker u_lepe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.duty       (out_ch.duty),
	.lamp_on    (out_ch.lamp_on),
	.effect_now (out_ch.effect_now),
	.active     (out_ch.active)
);

// ----- verif/lamp_duty_checker.sv -----
module lamp_duty_checker
	import lepe_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	lepe_in_if                        in_ch,
	lepe_out_if                       out_ch,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic                      pready,
	input  logic [APB_ADDR_BITS-1:0]  paddr,
	input  logic [31:0]               pwdata,
	output int                        fail_count,
	output int                        pending
);

	localparam int SINE_N = SINE_ENTRIES_DEF;
	localparam longint ELAPSED_CAP = 64'd1048576;
	localparam longint PHASE_FULL = 64'd65536;

	logic [15:0] sine_q16 [SINE_N];

	// shadow of the block state
	logic [7:0]  brightness_q;
	logic [15:0] rate_q;
	effect_t     lamp_mode;
	logic [31:0] t_start;
	logic [31:0] t_last;
	logic [15:0] p_a, p_b, p_c;
	longint      phase_q16;
	logic        level_q;
	logic [7:0]  duty_q;

	result_t lamp_due [$];
	result_t want, got;

	task automatic report_mismatch(input string msg);
		if (fail_count < 100)
			$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic void fill_sine();
		longint unsigned x, t;
		longint sum, v;
		for (int k = 0; k < SINE_N; k++) begin
			x = (PI_QUARTER_Q30 * longint'(k)) / longint'(SINE_N - 1);
			t = x;
			sum = longint'(x);
			for (int n = 1; n <= 5; n++) begin
				t = (((t * x) >> 30) * x) >> 30;
				t = t / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1)
					sum -= longint'(t);
				else
					sum += longint'(t);
			end
			if (sum < 0)
				sum = 0;
			v = (sum + 8192) >>> 14;
			if (v > 65535)
				v = 65535;
			sine_q16[k] = 16'(v);
		end
	endfunction

	function automatic void set_level(input logic on);
		level_q = on;
		duty_q = on ? brightness_q : 8'd0;
	endfunction

	function automatic void advance(input logic [31:0] now);
		logic [31:0] since, elapsed;
		longint unsigned a, t, e, idx, s;
		if (t_start > now)
			t_start = now;
		since = now - t_start;
		elapsed = now - t_last;
		case (lamp_mode)
			EFF_OFF: begin
				set_level(1'b0);
				lamp_mode = EFF_IDLE;
			end
			EFF_ON: set_level(1'b1);
			EFF_FADE_ON, EFF_FADE_OFF: begin
				a = p_a;
				if (a == 0) begin
					duty_q = brightness_q;
				end else begin
					t = (since < a) ? since : a;
					if (lamp_mode == EFF_FADE_OFF)
						t = a - t;
					duty_q = 8'((t * brightness_q) / a);
				end
			end
			EFF_BREATH: begin
				e = (elapsed < ELAPSED_CAP) ? elapsed : ELAPSED_CAP;
				if (p_c == 16'd1)
					phase_q16 += longint'((rate_q * e * 64'd256) / 64'd1000);
				else
					phase_q16 -= longint'((rate_q * e * 64'd2048) / 64'd5000);
				if (phase_q16 > PHASE_FULL) begin
					p_c = 16'd0;
					phase_q16 = PHASE_FULL;
				end else if (phase_q16 < 0) begin
					p_c = 16'd1;
					phase_q16 = 0;
				end
				idx = (longint'(phase_q16) * (SINE_N - 1) + 32768) >> 16;
				if (idx >= SINE_N)
					idx = SINE_N - 1;
				s = sine_q16[idx];
				duty_q = 8'(((PHASE_FULL - s) * brightness_q) >> 16);
			end
			EFF_BLINK: begin
				if (level_q) begin
					if (since > p_a) begin
						set_level(1'b0);
						t_start = now;
					end
				end else if (since > p_b) begin
					set_level(1'b1);
					t_start = now;
				end
			end
			EFF_BLINK_OFF, EFF_BLINK_ON: begin
				if (level_q) begin
					if (since > p_b) begin
						set_level(1'b0);
						t_start = now;
						p_a = p_a - 16'd1;
						if (p_a == 16'd0 && lamp_mode == EFF_BLINK_OFF)
							lamp_mode = EFF_OFF;
					end
				end else if (since > p_c) begin
					set_level(1'b1);
					t_start = now;
					if (p_a == 16'd1 && lamp_mode == EFF_BLINK_ON)
						lamp_mode = EFF_ON;
				end
			end
			default: ;
		endcase
		t_last = now;
	endfunction

	function automatic result_t predict_lamp(input logic [1:0] cmd, input logic [3:0] eff,
			input logic [31:0] now, input logic [15:0] v1, input logic [15:0] v2,
			input logic [15:0] v3);
		result_t r;
		case (cmd)
			CMD_TICK: advance(now);
			CMD_SET: begin
				set_level(1'b1);
				t_last = now;
				p_a = v1;
				p_b = v2;
				p_c = v3;
				lamp_mode = (eff > EFF_BLINK_ON) ? EFF_IDLE : effect_t'(eff);
				t_start = now;
				phase_q16 = 0;
				advance(now);
			end
			CMD_PERIOD: begin
				p_a = v1;
				p_b = v1;
			end
			default: ;
		endcase
		r.duty = duty_q;
		r.lamp_on = level_q;
		r.effect_now = lamp_mode;
		r.active = (lamp_mode != EFF_IDLE && lamp_mode != EFF_OFF);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_sine();
			brightness_q = BRIGHTNESS_RESET;
			rate_q = BREATH_RATE_RESET;
			lamp_mode = EFF_OFF;
			t_start = '0;
			t_last = '0;
			p_a = '0;
			p_b = '0;
			p_c = '0;
			phase_q16 = 0;
			level_q = 1'b0;
			duty_q = '0;
			lamp_due.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_BRIGHTNESS)
					brightness_q = pwdata[7:0];
				else
					rate_q = pwdata[15:0];
			end
			if (in_ch.valid && in_ch.ready)
				lamp_due.push_back(predict_lamp(in_ch.command, in_ch.effect, in_ch.time_ms,
					in_ch.first_value, in_ch.second_value, in_ch.third_value));
			if (out_ch.valid && out_ch.ready) begin
				got.duty = out_ch.duty;
				got.lamp_on = out_ch.lamp_on;
				got.effect_now = out_ch.effect_now;
				got.active = out_ch.active;
				if (lamp_due.size() == 0) begin
					report_mismatch("result with no transaction outstanding");
				end else begin
					want = lamp_due.pop_front();
					if (got.duty !== want.duty)
						report_mismatch($sformatf("duty got %0d want %0d",
							got.duty, want.duty));
					if (got.lamp_on !== want.lamp_on)
						report_mismatch($sformatf("lamp_on got %0b want %0b",
							got.lamp_on, want.lamp_on));
					if (got.effect_now !== want.effect_now)
						report_mismatch($sformatf("effect_now got %0d want %0d",
							got.effect_now, want.effect_now));
					if (got.active !== want.active)
						report_mismatch($sformatf("active got %0b want %0b",
							got.active, want.active));
				end
			end
			pending <= lamp_due.size();
		end
	end

endmodule

// ----- verif/tb_light_effect_pwm_engine.sv -----
module tb_light_effect_pwm_engine;
	import lepe_pkg::*;

	// cycles with no transaction on either channel before the run is abandoned
	localparam int STALL_LIMIT = 3000;
	// per-segment item budget for the random part
	localparam int SEG_ITEMS = 171;

	logic clk;
	logic arst_n;

	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [31:0]              pwdata;
	logic [31:0]              prdata;
	logic                     pready;

	lepe_in_if  req_ch ();
	lepe_out_if rsp_ch ();

	int lamp_failures;
	int lamp_pending;

	// idle percentages of both sides, changed between segments
	int send_idle_pct;
	int recv_idle_pct;

	// running millisecond timestamp and count of non-ignored items sent
	logic [31:0] now_ms;
	int          sent;

	light_effect_pwm_engine dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (req_ch),
		.out_ch  (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lamp_duty_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (req_ch),
		.out_ch     (rsp_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (lamp_failures),
		.pending    (lamp_pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly small values so that fades and blinks finish within a burst,
	// now and then the full 16-bit range
	function automatic logic [15:0] pick_value(input int limit);
		if ($urandom_range(9) == 0)
			return 16'($urandom());
		return 16'($urandom_range(limit));
	endfunction

	// offer one transaction, with random idle cycles ahead of it, and wait
	// for it to be taken; called and returning at a rising edge
	task automatic send_item(input logic [1:0] cmd, input logic [3:0] eff,
			input logic [31:0] t, input logic [15:0] v1, input logic [15:0] v2,
			input logic [15:0] v3);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.effect <= eff;
		req_ch.time_ms <= t;
		req_ch.first_value <= v1;
		req_ch.second_value <= v2;
		req_ch.third_value <= v3;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (cmd != CMD_NONE)
			sent++;
	endtask

	// a tick carries random junk in the fields it does not use
	task automatic send_tick(input logic [31:0] t);
		send_item(CMD_TICK, 4'($urandom()), t, 16'($urandom()), 16'($urandom()),
			16'($urandom()));
	endtask

	// apb write: setup cycle then access cycle
	task automatic write_reg(input logic reg_sel, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// stop offering and wait until every result has been taken
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (lamp_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one well-formed burst: set an effect, then mostly ticks with the clock
	// moving forward, salted with period commands, unused commands, time
	// going backwards, wild jumps and stray set commands
	task automatic random_burst();
		logic [3:0] eff;
		logic [15:0] v3;
		int pick;
		int steps;
		int step_max;
		pick = $urandom_range(99);
		eff = (pick < 6) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8, 0));
		v3 = pick_value(20);
		// breathing wants mostly a clean start direction
		if (eff == EFF_BREATH && $urandom_range(3) != 0)
			v3 = 16'($urandom_range(1));
		// breathing moves slowly in milliseconds, so give it longer strides
		step_max = (eff == EFF_BREATH) ? 300 : 20;
		now_ms += $urandom_range(30);
		send_item(CMD_SET, eff, now_ms, pick_value(40), pick_value(20), v3);
		steps = $urandom_range(16, 1);
		repeat (steps) begin
			pick = $urandom_range(99);
			if (pick < 78) begin
				now_ms += $urandom_range(step_max);
				send_tick(now_ms);
			end else if (pick < 84) begin
				send_item(CMD_PERIOD, 4'($urandom()), now_ms, pick_value(20),
					16'($urandom()), 16'($urandom()));
			end else if (pick < 88) begin
				send_item(CMD_NONE, 4'($urandom()), 32'($urandom()), 16'($urandom()),
					16'($urandom()), 16'($urandom()));
			end else if (pick < 93) begin
				now_ms -= $urandom_range(60);
				send_tick(now_ms);
			end else if (pick < 96) begin
				now_ms = 32'($urandom());
				send_tick(now_ms);
			end else begin
				send_item(CMD_SET, 4'($urandom()), now_ms, 16'($urandom()),
					16'($urandom()), 16'($urandom()));
			end
		end
	endtask

	// receiver: random stalls, plus one long hold-off once 300 results are in
	// so that the output register and controller fill and the input stalls
	initial begin : receiver
		int taken;
		int hold_left;
		bit held;
		taken = 0;
		hold_left = 0;
		held = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				taken++;
			if (!held && taken >= 300) begin
				held = 1'b1;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no transaction at all
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int seg;
		int target;
		logic [7:0] br_set;
		logic [15:0] rate_set;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_TICK;
		req_ch.effect = EFF_IDLE;
		req_ch.time_ms = '0;
		req_ch.first_value = '0;
		req_ch.second_value = '0;
		req_ch.third_value = '0;
		send_idle_pct = 23;
		recv_idle_pct = 67;
		sent = 0;
		now_ms = 32'd1000;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset register values
		// off after reset drops to idle, then idle stays put, unused command
		send_tick(32'd1000);
		send_tick(32'd1001);
		send_item(CMD_NONE, EFF_ON, 32'd1002, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// on and off, all-ones values
		send_item(CMD_SET, EFF_ON, 32'd1010, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(CMD_SET, EFF_OFF, 32'd1012, 16'h0000, 16'h0000, 16'h0000);
		// fade on over 100 ms, mid-way and saturated
		send_item(CMD_SET, EFF_FADE_ON, 32'd2000, 16'd100, 16'd0, 16'd0);
		send_tick(32'd2050);
		send_tick(32'd2300);
		// fades of zero length give full brightness
		send_item(CMD_SET, EFF_FADE_ON, 32'd2400, 16'd0, 16'd0, 16'd0);
		send_item(CMD_SET, EFF_FADE_OFF, 32'd2500, 16'd0, 16'd0, 16'd0);
		// fade off over 40 ms, then time stepping behind the start
		send_item(CMD_SET, EFF_FADE_OFF, 32'd2600, 16'd40, 16'd0, 16'd0);
		send_tick(32'd2620);
		send_tick(32'd2550);
		send_tick(32'd2700);
		// breathing rising to the top, flipping, then falling
		send_item(CMD_SET, EFF_BREATH, 32'd3000, 16'd0, 16'd0, 16'd1);
		send_tick(32'd4000);
		send_tick(32'd4500);
		send_tick(32'd6000);
		// breathing with an elapsed time far beyond the cap
		send_item(CMD_SET, EFF_BREATH, 32'd0, 16'd0, 16'd0, 16'd0);
		send_tick(32'hFFFF_FFFF);
		// blink 3 on 5 off, then a new period for both halves
		send_item(CMD_SET, EFF_BLINK, 32'd7000, 16'd3, 16'd5, 16'd0);
		send_tick(32'd7004);
		send_tick(32'd7010);
		send_item(CMD_PERIOD, EFF_IDLE, 32'd7011, 16'd2, 16'd9, 16'd9);
		send_tick(32'd7020);
		// counted blink ending off, one blink
		send_item(CMD_SET, EFF_BLINK_OFF, 32'd8000, 16'd1, 16'd0, 16'd0);
		send_tick(32'd8001);
		// counted blink ending on, two blinks
		send_item(CMD_SET, EFF_BLINK_ON, 32'd9000, 16'd2, 16'd0, 16'd0);
		send_tick(32'd9001);
		send_tick(32'd9002);
		// counted blink from zero wraps the count
		send_item(CMD_SET, EFF_BLINK_OFF, 32'd9100, 16'd0, 16'd0, 16'd0);
		send_tick(32'd9101);
		// unknown effect codes load as idle
		send_item(CMD_SET, 4'd15, 32'd9200, 16'd7, 16'd7, 16'd7);
		send_item(CMD_SET, 4'd9, 32'd9201, 16'd7, 16'd7, 16'd7);

		// random part in segments, each under its own register setting
		target = sent;
		for (seg = 0; seg < 6; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 67;
				end
				1: begin
					send_idle_pct = 67;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (seg)
				0: begin
					br_set = 8'd255;
					rate_set = 16'hFFFF;
				end
				1: begin
					br_set = 8'd0;
					rate_set = 16'd0;
				end
				2: begin
					br_set = 8'd1;
					rate_set = 16'd1;
				end
				5: begin
					br_set = BRIGHTNESS_RESET;
					rate_set = BREATH_RATE_RESET;
				end
				default: begin
					br_set = 8'($urandom());
					rate_set = 16'($urandom());
				end
			endcase
			// registers only change with nothing in flight
			wait_idle();
			write_reg(REG_BRIGHTNESS, {24'd0, br_set});
			write_reg(REG_BREATH_RATE, {16'd0, rate_set});
			if (seg % 2 == 1)
				now_ms = 32'($urandom());
			target += SEG_ITEMS;
			while (sent < target)
				random_burst();
		end

		wait_idle();
		repeat (30) @(posedge clk);
		if (lamp_failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
